// ===== rtl/clmf_pkg.sv =====
`default_nettype none

package clmf_pkg;

	localparam int MAX_HITS  = 64;
	localparam int IDX_W     = $clog2(MAX_HITS);
	localparam int CNT_W     = $clog2(MAX_HITS + 1);

	localparam int ENERGY_W  = 24;
	localparam int SECTOR_W  = 8;
	localparam int COORD_W   = 18;
	localparam int LIMXY_W   = 17;
	localparam int CROSS_W   = 18;
	localparam int INDEX_W   = 6;

	localparam int SQ_W      = 2 * COORD_W;
	localparam int ACC_W     = SQ_W + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MODE = 3'd4;

	typedef logic [INDEX_W-1:0] index_t;

	// one stored hit, coordinates as raw two's complement bits
	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [SECTOR_W-1:0] sector;
		logic [COORD_W-1:0]  local_x;
		logic [COORD_W-1:0]  local_y;
		logic [COORD_W-1:0]  global_x;
		logic [COORD_W-1:0]  global_y;
		logic [COORD_W-1:0]  global_z;
	} hit_t;

	localparam int HIT_W = $bits(hit_t);

	typedef struct packed {
		logic [ENERGY_W-1:0] center_threshold;
		logic [LIMXY_W-1:0]  local_limit_x;
		logic [LIMXY_W-1:0]  local_limit_y;
		logic [CROSS_W-1:0]  cross_sector_limit;
		logic                global_mode;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic kill;
	} pair_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/clmf_ram.sv =====
`default_nettype none

module clmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/clmf_pair_unit.sv =====
`default_nettype none

// Decides whether hit b is a higher-energy neighbor of hit a.
// Cross-sector distance runs through one 18x18 squarer, one term per cycle.
module clmf_pair_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire clmf_pkg::hit_t    hit_a,
	input  wire clmf_pkg::hit_t    hit_b,
	input  wire clmf_pkg::cfg_t    cfg,
	output clmf_pkg::pair_rsp_t    rsp
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_EVAL = 2'd1;
	localparam logic [1:0] P_MUL  = 2'd2;

	localparam logic [2:0] STEP_LIM  = 3'd3;
	localparam logic [2:0] STEP_LAST = 3'd4;

	function automatic logic [clmf_pkg::COORD_W-1:0] abs_diff(
		input logic [clmf_pkg::COORD_W-1:0] a,
		input logic [clmf_pkg::COORD_W-1:0] b
	);
		logic [clmf_pkg::COORD_W:0] d;
		d = {a[clmf_pkg::COORD_W-1], a} - {b[clmf_pkg::COORD_W-1], b};
		if (d[clmf_pkg::COORD_W]) begin
			d = -d;
		end
		return d[clmf_pkg::COORD_W-1:0];
	endfunction

	logic [1:0]                      state_q;
	logic [2:0]                      step_q;
	logic                            greater_q;
	logic                            same_q;
	logic [clmf_pkg::COORD_W-1:0]    dlx_q, dly_q, dx_q, dy_q, dz_q;
	logic [clmf_pkg::SQ_W-1:0]       mul_q;
	logic [clmf_pkg::ACC_W-1:0]      acc_q;
	logic [clmf_pkg::COORD_W-1:0]    op;
	logic                            local_hit;

	assign local_hit = (dlx_q <= {1'b0, cfg.local_limit_x}) &&
	                   (dly_q <= {1'b0, cfg.local_limit_y});

	always_comb begin
		case (step_q)
			3'd0:    op = dx_q;
			3'd1:    op = dy_q;
			3'd2:    op = dz_q;
			default: op = clmf_pkg::COORD_W'(cfg.cross_sector_limit);
		endcase
	end

	always_comb begin
		rsp = '0;
		case (state_q)
			P_EVAL: begin
				if (!greater_q) begin
					rsp.done = 1'b1;
				end else if (same_q) begin
					rsp.done = 1'b1;
					rsp.kill = local_hit;
				end
			end
			P_MUL: begin
				if (step_q == STEP_LAST) begin
					rsp.done = 1'b1;
					rsp.kill = (acc_q <= clmf_pkg::ACC_W'(mul_q));
				end
			end
			default: rsp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (start) begin
						state_q <= P_EVAL;
					end
				end
				P_EVAL: begin
					step_q <= '0;
					if (!greater_q || same_q) begin
						state_q <= P_IDLE;
					end else begin
						state_q <= P_MUL;
					end
				end
				P_MUL: begin
					if (step_q == STEP_LAST) begin
						state_q <= P_IDLE;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && start) begin
			greater_q <= hit_b.energy > hit_a.energy;
			same_q    <= hit_b.sector == hit_a.sector;
			dlx_q     <= abs_diff(hit_a.local_x, hit_b.local_x);
			dly_q     <= abs_diff(hit_a.local_y, hit_b.local_y);
			dx_q      <= abs_diff(hit_a.global_x, hit_b.global_x);
			dy_q      <= abs_diff(hit_a.global_y, hit_b.global_y);
			dz_q      <= abs_diff(hit_a.global_z, hit_b.global_z);
		end
		if (state_q == P_EVAL) begin
			acc_q <= '0;
		end
		if (state_q == P_MUL) begin
			if (step_q <= STEP_LIM) begin
				mul_q <= clmf_pkg::SQ_W'(op) * clmf_pkg::SQ_W'(op);
			end
			// add the previous square; lim squared stays in mul_q for the compare
			if (step_q != 3'd0 && step_q <= STEP_LIM) begin
				acc_q <= acc_q + clmf_pkg::ACC_W'(mul_q);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/calorimeter_local_maxima_finder_unit.sv =====
`default_nettype none

// Calorimeter local-maxima finder. Hits of one group are loaded one per input
// transaction into a hit memory of clmf_pkg::MAX_HITS entries; hits beyond
// that are dropped, but a last_hit mark still closes the group.
// After the transaction with last_hit, in_ready stays low while the block
// gives one output transaction per stored hit, in load order, with
// last_result on the final one; then the group is empty and loading resumes.
// In split mode (global_mode = 0) a hit is flagged when its energy is at least
// center_threshold and no neighbor has strictly greater energy. Same-sector
// neighbors lie within local_limit_x / local_limit_y in |dx| / |dy| of local
// coordinates; cross-sector neighbors have dx^2+dy^2+dz^2 of global
// coordinates at most cross_sector_limit^2. In global mode only the first
// highest-energy hit can be flagged. Configuration writes are taken at any
// time but must only happen while the block is idle.
// Sequence: once a group is closed, a scan over all stored hits finds the
// highest hit. Each hit is then read and tested against the threshold, and
// in split mode, when it passes, compared in turn with every other hit,
// skipping itself; hits that are not higher or sit in the same sector are
// decided without the squarer, higher hits in another sector go through it,
// and the comparison ends early at the first higher neighbor. The single
// memory read port and the one squarer, reused for each distance term,
// serialize this work; each result then waits for the output handshake.
module calorimeter_local_maxima_finder_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 cfg_we,
	input  wire logic [clmf_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  wire logic [clmf_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [clmf_pkg::ENERGY_W-1:0]        energy,
	input  wire logic [clmf_pkg::SECTOR_W-1:0]        sector,
	input  wire logic signed [clmf_pkg::COORD_W-1:0]  local_x,
	input  wire logic signed [clmf_pkg::COORD_W-1:0]  local_y,
	input  wire logic signed [clmf_pkg::COORD_W-1:0]  global_x,
	input  wire logic signed [clmf_pkg::COORD_W-1:0]  global_y,
	input  wire logic signed [clmf_pkg::COORD_W-1:0]  global_z,
	input  wire logic                                 last_hit,

	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [clmf_pkg::INDEX_W-1:0]              hit_index,
	output logic                                      is_maximum,
	output logic                                      last_result
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;  // loading hits
	localparam logic [2:0] ST_BEST   = 3'd1;  // scan for the highest hit
	localparam logic [2:0] ST_CENTER = 3'd2;  // read candidate i
	localparam logic [2:0] ST_CWAIT  = 3'd3;  // latch candidate, threshold test
	localparam logic [2:0] ST_JRD    = 3'd4;  // read other hit j
	localparam logic [2:0] ST_JWAIT  = 3'd5;  // hand pair to the pair unit
	localparam logic [2:0] ST_PAIR   = 3'd6;  // wait for pair decision
	localparam logic [2:0] ST_EMIT   = 3'd7;  // result waits for out_ready

	logic [2:0]                      state_q;
	clmf_pkg::cfg_t                  cfg_q;
	logic [clmf_pkg::CNT_W-1:0]      count_q;
	logic [clmf_pkg::CNT_W-1:0]      k_q;
	logic [clmf_pkg::CNT_W-1:0]      j_q;
	logic [clmf_pkg::IDX_W-1:0]      i_q;
	logic [clmf_pkg::IDX_W-1:0]      best_q;
	logic [clmf_pkg::ENERGY_W-1:0]   best_e_q;
	logic                            rd_s1;
	logic [clmf_pkg::IDX_W-1:0]      idx_s1;
	logic                            ismax_q;
	clmf_pkg::hit_t                  hit_a_q;

	clmf_pkg::hit_t                  wr_hit;
	clmf_pkg::hit_t                  rd_hit;
	logic [clmf_pkg::IDX_W-1:0]      rd_addr;
	logic                            in_xact;
	logic                            out_xact;
	logic                            wr_en;
	logic                            issue;
	logic                            pair_start;
	clmf_pkg::pair_rsp_t             pair_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xact   = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_xact  = out_valid && out_ready;

	assign wr_en = in_xact && (count_q < clmf_pkg::CNT_W'(clmf_pkg::MAX_HITS));
	assign issue = (state_q == ST_BEST) && (k_q != count_q);
	assign pair_start = (state_q == ST_JWAIT);

	assign hit_index   = clmf_pkg::index_t'(i_q);
	assign is_maximum  = ismax_q;
	assign last_result = (clmf_pkg::CNT_W'(i_q) + clmf_pkg::CNT_W'(1)) == count_q;

	always_comb begin
		wr_hit.energy   = energy;
		wr_hit.sector   = sector;
		wr_hit.local_x  = local_x;
		wr_hit.local_y  = local_y;
		wr_hit.global_x = global_x;
		wr_hit.global_y = global_y;
		wr_hit.global_z = global_z;
	end

	always_comb begin
		case (state_q)
			ST_BEST: rd_addr = k_q[clmf_pkg::IDX_W-1:0];
			ST_JRD:  rd_addr = j_q[clmf_pkg::IDX_W-1:0];
			default: rd_addr = i_q;
		endcase
	end

	clmf_ram #(
		.WIDTH (clmf_pkg::HIT_W),
		.DEPTH (clmf_pkg::MAX_HITS)
	) u_hit_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[clmf_pkg::IDX_W-1:0]),
		.wdata (wr_hit),
		.raddr (rd_addr),
		.rdata (rd_hit)
	);

	clmf_pair_unit u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pair_start),
		.hit_a  (hit_a_q),
		.hit_b  (rd_hit),
		.cfg    (cfg_q),
		.rsp    (pair_rsp)
	);

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				clmf_pkg::REG_CENTER_THR:
					cfg_q.center_threshold <= cfg_data;
				clmf_pkg::REG_LOCAL_X:
					cfg_q.local_limit_x <= cfg_data[clmf_pkg::LIMXY_W-1:0];
				clmf_pkg::REG_LOCAL_Y:
					cfg_q.local_limit_y <= cfg_data[clmf_pkg::LIMXY_W-1:0];
				clmf_pkg::REG_CROSS_LIMIT:
					cfg_q.cross_sector_limit <= cfg_data[clmf_pkg::CROSS_W-1:0];
				clmf_pkg::REG_GLOBAL_MODE:
					cfg_q.global_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
			j_q     <= '0;
			i_q     <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						if (wr_en) begin
							count_q <= count_q + clmf_pkg::CNT_W'(1);
						end
						if (last_hit) begin
							k_q     <= '0;
							state_q <= ST_BEST;
						end
					end
				end
				ST_BEST: begin
					if (issue) begin
						k_q <= k_q + clmf_pkg::CNT_W'(1);
					end
					if (rd_s1 &&
					    (clmf_pkg::CNT_W'(idx_s1) + clmf_pkg::CNT_W'(1)) == count_q) begin
						i_q     <= '0;
						state_q <= ST_CENTER;
					end
				end
				ST_CENTER: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					j_q <= '0;
					if (cfg_q.global_mode || rd_hit.energy < cfg_q.center_threshold) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_JRD;
					end
				end
				ST_JRD: begin
					if (j_q == count_q) begin
						state_q <= ST_EMIT;
					end else if (j_q[clmf_pkg::IDX_W-1:0] == i_q) begin
						j_q <= j_q + clmf_pkg::CNT_W'(1);
					end else begin
						state_q <= ST_JWAIT;
					end
				end
				ST_JWAIT: state_q <= ST_PAIR;
				ST_PAIR: begin
					if (pair_rsp.done) begin
						if (pair_rsp.kill) begin
							state_q <= ST_EMIT;
						end else begin
							j_q     <= j_q + clmf_pkg::CNT_W'(1);
							state_q <= ST_JRD;
						end
					end
				end
				ST_EMIT: begin
					if (out_xact) begin
						if (last_result) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + clmf_pkg::IDX_W'(1);
							state_q <= ST_CENTER;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= k_q[clmf_pkg::IDX_W-1:0];
		// first strictly higher energy wins
		if (state_q == ST_BEST && rd_s1) begin
			if (idx_s1 == '0 || best_e_q < rd_hit.energy) begin
				best_q   <= idx_s1;
				best_e_q <= rd_hit.energy;
			end
		end
		if (state_q == ST_CWAIT) begin
			hit_a_q <= rd_hit;
			ismax_q <= (rd_hit.energy >= cfg_q.center_threshold) &&
			           (!cfg_q.global_mode || i_q == best_q);
		end
		if (state_q == ST_PAIR && pair_rsp.done && pair_rsp.kill) begin
			ismax_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/clmf_checker.sv =====
`default_nettype none

module clmf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          last_hit,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [clmf_pkg::INDEX_W-1:0]  hit_index,
	input wire logic                          is_maximum,
	input wire logic                          last_result
);

	// no loading while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	// closing a group stops loading
	a_close_group: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_hit |=> !in_ready)
		else $error("block still loading after last hit");

	// final result reopens loading
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_result |=> in_ready && !out_valid)
		else $error("block not idle after final result");

	// results are spaced by candidate evaluation
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=> !out_valid && !in_ready)
		else $error("back-to-back results");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_index) &&
			$stable(is_maximum) && $stable(last_result))
		else $error("stalled result changed");

endmodule

bind calorimeter_local_maxima_finder_unit clmf_checker u_clmf_checker (.*);

`default_nettype wire
